[rtl/prm_pkg.sv]
// ----------------------------------------------------------------------------
// prm_pkg
// Types and constants shared by the per-pixel running statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package prm_pkg;

   // Request modes
   typedef enum logic [1:0] {
      MODE_ADD   = 2'd0,
      MODE_READ  = 2'd1,
      MODE_CLEAR = 2'd2
   } mode_type;

   // Register indexes of the configuration port
   typedef enum logic [1:0] {
      CSR_X_START = 2'd0,
      CSR_Y_START = 2'd1,
      CSR_X_END   = 2'd2,
      CSR_Y_END   = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_INIT_CLR,
      ST_IDLE,
      ST_DECODE,
      ST_FETCH,
      ST_SDIV,
      ST_SMUL,
      ST_SSUM,
      ST_VDIV,
      ST_QDIV,
      ST_SQRT,
      ST_CLEAR,
      ST_DONE
   } state_type;

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;
   localparam logic [47:0] VAR_MAX   = 48'hFFFF_FFFF_FFFF;

   // One table entry
   typedef struct packed {
      logic [63:0] sum;
      logic [31:0] mean;
      logic [15:0] count;
   } entry_type;

   // Command to the shared divider
   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [15:0] divisor;
      logic [6:0]  steps;
   } div_req_type;

   // Result fields
   typedef struct packed {
      logic        accepted;
      logic [15:0] sample_count;
      logic [31:0] mean_value;
      logic [47:0] variance_value;
      logic [31:0] std_error;
      logic        too_few;
   } result_type;

endpackage

`default_nettype wire

[rtl/prm_if.sv]
// ----------------------------------------------------------------------------
// prm_if
// Request, response and configuration channels of the statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

interface prm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [11:0] pixel_x;
   logic [11:0] pixel_y;
   logic [11:0] sample_x;
   logic [11:0] sample_y;
   logic [31:0] luminance;

   modport source (output valid, mode, pixel_x, pixel_y, sample_x, sample_y, luminance,
                   input ready);
   modport sink   (input valid, mode, pixel_x, pixel_y, sample_x, sample_y, luminance,
                   output ready);
endinterface

interface prm_rsp_if;
   logic        valid;
   logic        ready;
   logic        accepted;
   logic [15:0] sample_count;
   logic [31:0] mean_value;
   logic [47:0] variance_value;
   logic [31:0] std_error;
   logic        too_few;

   modport source (output valid, accepted, sample_count, mean_value, variance_value,
                   std_error, too_few, input ready);
   modport sink   (input valid, accepted, sample_count, mean_value, variance_value,
                   std_error, too_few, output ready);
endinterface

interface prm_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [12:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/pixel_running_mean_variance.sv]
// ----------------------------------------------------------------------------
// pixel_running_mean_variance
// Per-pixel running mean and variance of luminance over one image tile.
// ----------------------------------------------------------------------------
// Requests arrive on req: mode add folds a luminance into the pixel's entry
// (when pixel and sample lie in the tile), mode read returns count, mean,
// unbiased variance and standard error, mode clear zeroes the table. Every
// request yields exactly one response on rsp. The csr channel sets the tile
// rectangle and is always ready; the user must write it only while the block
// is idle (not enforced). One shared 64-by-16 divider and a square root unit,
// each one bit a cycle, run under a sequencer, one request at a time:
//   add:   32-bit quotient divide, multiply, table write
//   read:  64-bit and 48-bit quotient divides, 32-bit root
//   clear: one table entry a cycle
// req.ready is high only while idle. After reset the table is swept to zero
// before the first request is taken. A response waits in an output register
// while the receiver stalls; the next request is taken meanwhile and holds
// in its last step until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_running_mean_variance #(
   parameter int TILE_WIDTH  = 16,
   parameter int TILE_HEIGHT = 16
) (
   input wire logic   clock,
   input wire logic   reset,
   prm_req_if.sink    req,
   prm_rsp_if.source  rsp,
   prm_csr_if.sink    csr
);

   localparam int TableSize = TILE_WIDTH * TILE_HEIGHT;
   localparam int IdxW      = (TableSize > 1) ? $clog2(TableSize) : 1;
   localparam logic [IdxW-1:0] LastIdx = IdxW'(TableSize - 1);

   prm_pkg::state_type   state_ff, state_in;
   prm_pkg::result_type  res_ff, res_in;
   prm_pkg::result_type  out_ff;
   prm_pkg::entry_type   mem [TableSize];
   prm_pkg::entry_type   rd_data_ff;
   prm_pkg::entry_type   wr_data;
   prm_pkg::div_req_type div_req;

   logic [11:0] xs_ff, ys_ff;
   logic [12:0] xe_ff, ye_ff;
   logic [1:0]  mode_ff;
   logic [11:0] px_ff, py_ff, sx_ff, sy_ff;
   logic [31:0] lum_ff;

   logic [15:0] n_ff, n_in;
   logic        up_ff, up_in;
   logic [31:0] d1_ff, d1_in;
   logic [31:0] mean_ff, mean_in;
   logic [31:0] d2_ff, d2_in;
   logic [63:0] prod_ff;
   logic [IdxW-1:0] clr_ff, clr_in;
   logic        rsp_valid_ff;
   logic        out_load;

   logic [11:0] lx, ly;
   logic        pix_hit, smp_rect;
   logic [IdxW-1:0] idx;
   logic        wr_en;
   logic [IdxW-1:0] wr_addr;
   logic        div_done;
   logic [63:0] quo;
   logic        sqrt_start;
   logic [63:0] sqrt_val;
   logic        sqrt_done;
   logic [31:0] sqrt_root;

   logic [15:0] n_c;
   logic        up_c;
   logic [31:0] d1_c, step_c, mean_c;
   logic [64:0] sum_c;
   logic [47:0] var_c;
   logic        accept;

   assign accept    = req.valid && req.ready;
   assign req.ready = (state_ff == prm_pkg::ST_IDLE);
   assign csr.ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         xs_ff <= 12'd0;
         ys_ff <= 12'd0;
         xe_ff <= 13'd16;
         ye_ff <= 13'd16;
      end else if (csr.valid) begin
         case (csr.index)
            prm_pkg::CSR_X_START: xs_ff <= csr.data[11:0];
            prm_pkg::CSR_Y_START: ys_ff <= csr.data[11:0];
            prm_pkg::CSR_X_END:   xe_ff <= csr.data;
            prm_pkg::CSR_Y_END:   ye_ff <= csr.data;
            default: ;
         endcase
      end
   end

   // Hold the accepted request
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req.mode;
         px_ff   <= req.pixel_x;
         py_ff   <= req.pixel_y;
         sx_ff   <= req.sample_x;
         sy_ff   <= req.sample_y;
         lum_ff  <= req.luminance;
      end
   end

   // Tile tests and table index
   always_comb begin
      lx = px_ff - xs_ff;
      ly = py_ff - ys_ff;
      pix_hit = (px_ff >= xs_ff) && ({1'b0, px_ff} < xe_ff) &&
                (py_ff >= ys_ff) && ({1'b0, py_ff} < ye_ff) &&
                ({1'b0, lx} < 13'(TILE_WIDTH)) && ({1'b0, ly} < 13'(TILE_HEIGHT));
      smp_rect = (sx_ff >= xs_ff) && ({1'b0, sx_ff} < xe_ff) &&
                 (sy_ff >= ys_ff) && ({1'b0, sy_ff} < ye_ff);
      idx = IdxW'(32'(ly) * TILE_WIDTH + 32'(lx));
   end

   // Statistics table, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[idx];
   end

   // Shared arithmetic units
   prm_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_req),
      .done     (div_done),
      .quotient (quo)
   );

   prm_isqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .value (sqrt_val),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      res_in     = res_ff;
      n_in       = n_ff;
      up_in      = up_ff;
      d1_in      = d1_ff;
      mean_in    = mean_ff;
      d2_in      = d2_ff;
      clr_in     = clr_ff;
      wr_en      = 1'b0;
      wr_addr    = idx;
      wr_data    = '0;
      div_req    = '0;
      sqrt_start = 1'b0;
      sqrt_val   = '0;
      out_load   = 1'b0;

      n_c    = (rd_data_ff.count == prm_pkg::COUNT_MAX) ? rd_data_ff.count
                                                        : rd_data_ff.count + 16'd1;
      up_c   = lum_ff >= rd_data_ff.mean;
      d1_c   = up_c ? lum_ff - rd_data_ff.mean : rd_data_ff.mean - lum_ff;
      step_c = quo[31:0];
      mean_c = up_ff ? rd_data_ff.mean + step_c : rd_data_ff.mean - step_c;
      sum_c  = {1'b0, rd_data_ff.sum} + {17'd0, prod_ff[63:16]};
      var_c  = (quo[63:48] != 16'd0) ? prm_pkg::VAR_MAX : quo[47:0];

      case (state_ff)
         prm_pkg::ST_INIT_CLR, prm_pkg::ST_CLEAR: begin
            // Sweep the table to zero
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == LastIdx) begin
               clr_in   = '0;
               state_in = (state_ff == prm_pkg::ST_CLEAR) ? prm_pkg::ST_DONE
                                                          : prm_pkg::ST_IDLE;
            end
         end
         prm_pkg::ST_IDLE: begin
            res_in = '0;
            if (accept) begin
               state_in = prm_pkg::ST_DECODE;
            end
         end
         prm_pkg::ST_DECODE: begin
            case (mode_ff)
               prm_pkg::MODE_ADD: begin
                  state_in = (pix_hit && smp_rect) ? prm_pkg::ST_FETCH : prm_pkg::ST_DONE;
               end
               prm_pkg::MODE_READ: begin
                  if (pix_hit) begin
                     state_in = prm_pkg::ST_FETCH;
                  end else begin
                     res_in.too_few = 1'b1;
                     state_in       = prm_pkg::ST_DONE;
                  end
               end
               prm_pkg::MODE_CLEAR: begin
                  clr_in   = '0;
                  state_in = prm_pkg::ST_CLEAR;
               end
               default: state_in = prm_pkg::ST_DONE;
            endcase
         end
         prm_pkg::ST_FETCH: begin
            if (mode_ff == prm_pkg::MODE_ADD) begin
               // Divide delta by the new count
               n_in             = n_c;
               up_in            = up_c;
               d1_in            = d1_c;
               div_req.start    = 1'b1;
               div_req.dividend = {d1_c, 32'd0};
               div_req.divisor  = n_c;
               div_req.steps    = 7'd32;
               state_in         = prm_pkg::ST_SDIV;
            end else begin
               res_in.sample_count = rd_data_ff.count;
               res_in.mean_value   = rd_data_ff.mean;
               if (rd_data_ff.count < 16'd2) begin
                  res_in.too_few = 1'b1;
                  state_in       = prm_pkg::ST_DONE;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = rd_data_ff.sum;
                  div_req.divisor  = rd_data_ff.count - 16'd1;
                  div_req.steps    = 7'd64;
                  state_in         = prm_pkg::ST_VDIV;
               end
            end
         end
         prm_pkg::ST_SDIV: begin
            if (div_done) begin
               mean_in  = mean_c;
               d2_in    = up_ff ? lum_ff - mean_c : mean_c - lum_ff;
               state_in = prm_pkg::ST_SMUL;
            end
         end
         prm_pkg::ST_SMUL: begin
            state_in = prm_pkg::ST_SSUM;
         end
         prm_pkg::ST_SSUM: begin
            // Saturating sum update and write back
            wr_en         = 1'b1;
            wr_data.count = n_ff;
            wr_data.mean  = mean_ff;
            wr_data.sum   = sum_c[64] ? {64{1'b1}} : sum_c[63:0];
            res_in.accepted = 1'b1;
            state_in      = prm_pkg::ST_DONE;
         end
         prm_pkg::ST_VDIV: begin
            if (div_done) begin
               res_in.variance_value = var_c;
               div_req.start    = 1'b1;
               div_req.dividend = {var_c, 16'd0};
               div_req.divisor  = rd_data_ff.count;
               div_req.steps    = 7'd48;
               state_in         = prm_pkg::ST_QDIV;
            end
         end
         prm_pkg::ST_QDIV: begin
            if (div_done) begin
               sqrt_start = 1'b1;
               sqrt_val   = {quo[47:0], 16'd0};
               state_in   = prm_pkg::ST_SQRT;
            end
         end
         prm_pkg::ST_SQRT: begin
            if (sqrt_done) begin
               res_in.std_error = sqrt_root;
               state_in         = prm_pkg::ST_DONE;
            end
         end
         prm_pkg::ST_DONE: begin
            // Hand off once the output register is free
            if (!rsp_valid_ff || rsp.ready) begin
               out_load = 1'b1;
               state_in = prm_pkg::ST_IDLE;
            end
         end
         default: state_in = prm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= prm_pkg::ST_INIT_CLR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      res_ff  <= res_in;
      n_ff    <= n_in;
      up_ff   <= up_in;
      d1_ff   <= d1_in;
      mean_ff <= mean_in;
      d2_ff   <= d2_in;
      prod_ff <= 64'(d1_ff) * 64'(d2_ff);
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ff <= res_ff;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.accepted       = out_ff.accepted;
   assign rsp.sample_count   = out_ff.sample_count;
   assign rsp.mean_value     = out_ff.mean_value;
   assign rsp.variance_value = out_ff.variance_value;
   assign rsp.std_error      = out_ff.std_error;
   assign rsp.too_few        = out_ff.too_few;

   // Checks
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == prm_pkg::ST_IDLE) |-> !wr_en)
      else $error("table written while idle");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req.ready)
      else $error("ready right after an accepted request");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || rsp.ready))
      else $error("output register overwritten");

   a_add_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.accepted) |-> (!rsp.too_few && rsp.sample_count == 16'd0))
      else $error("sample response carries statistics");

endmodule

`default_nettype wire

[rtl/prm_divider.sv]
// ----------------------------------------------------------------------------
// prm_divider
// Shared restoring divider, one quotient bit per cycle, 64 by 16 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module prm_divider (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire prm_pkg::div_req_type cmd,
   output logic                      done,
   output logic [63:0]               quotient
);

   logic [63:0] dvd_ff;
   logic [15:0] dsr_ff;
   logic [15:0] rem_ff;
   logic [15:0] rem_in;
   logic [63:0] quo_ff;
   logic [6:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [16:0] rem_sh;
   logic [16:0] rem_sub;
   logic        fits;

   // Trial subtract of the divisor from the shifted remainder
   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[63]};
      fits    = rem_sh >= {1'b0, dsr_ff};
      rem_sub = rem_sh - {1'b0, dsr_ff};
      rem_in  = fits ? rem_sub[15:0] : rem_sh[15:0];
   end

   // Load on start, advance one bit a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            dvd_ff  <= cmd.dividend;
            dsr_ff  <= cmd.divisor;
            rem_ff  <= '0;
            quo_ff  <= '0;
            cnt_ff  <= cmd.steps;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            dvd_ff <= {dvd_ff[62:0], 1'b0};
            rem_ff <= rem_in;
            quo_ff <= {quo_ff[62:0], fits};
            cnt_ff <= cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

[rtl/prm_isqrt.sv]
// ----------------------------------------------------------------------------
// prm_isqrt
// Digit-by-digit integer square root of a 64-bit value, one root bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module prm_isqrt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] value,
   output logic             done,
   output logic [31:0]      root
);

   logic [63:0] v_ff;
   logic [32:0] rem_ff;
   logic [32:0] rem_in;
   logic [31:0] root_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [34:0] rem_sh;
   logic [34:0] trial;
   logic [34:0] rem_sub;
   logic        fits;

   // Bring down two bits and try root*4+1
   always_comb begin
      rem_sh  = {rem_ff, v_ff[63:62]};
      trial   = {1'b0, root_ff, 2'b01};
      fits    = rem_sh >= trial;
      rem_sub = rem_sh - trial;
      rem_in  = fits ? rem_sub[32:0] : rem_sh[32:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            v_ff    <= value;
            rem_ff  <= '0;
            root_ff <= '0;
            cnt_ff  <= 6'd32;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            v_ff    <= {v_ff[61:0], 2'b00};
            rem_ff  <= rem_in;
            root_ff <= {root_ff[30:0], fits};
            cnt_ff  <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire
